/* rtl/core/intcode_step_machine_assert.svh */
// Assertion macros used by the step machine port checker.
`ifndef INTCODE_STEP_MACHINE_ASSERT_SVH
`define INTCODE_STEP_MACHINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("step machine check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ISM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("step machine check failed");

`endif

/* rtl/core/ism_pkg.sv */
// Shared types, constants and helper functions of the Intcode step machine.
package ism_pkg;

  // Sizes
  localparam int MEM_WORDS = 4096;
  localparam int INQ_DEPTH = 32;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int PC_W      = $clog2(MEM_WORDS + 4);
  localparam int QP_W      = $clog2(2 * INQ_DEPTH);
  localparam int QI_W      = $clog2(INQ_DEPTH);
  localparam int DEC_BITS  = 3;
  localparam int DEC_STEPS = 63 / DEC_BITS;
  localparam int DC_W      = $clog2(DEC_STEPS);

  // Command codes
  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_PUSH  = 2'd2;
  localparam logic [1:0] CMD_STEP  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_HALT  = 3'd2;
  localparam logic [2:0] ST_FAULT = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // Opcodes
  localparam logic [6:0] OP_ADD  = 7'd1;
  localparam logic [6:0] OP_MUL  = 7'd2;
  localparam logic [6:0] OP_IN   = 7'd3;
  localparam logic [6:0] OP_OUT  = 7'd4;
  localparam logic [6:0] OP_JT   = 7'd5;
  localparam logic [6:0] OP_JF   = 7'd6;
  localparam logic [6:0] OP_LT   = 7'd7;
  localparam logic [6:0] OP_EQ   = 7'd8;
  localparam logic [6:0] OP_ARB  = 7'd9;
  localparam logic [6:0] OP_HALT = 7'd99;

  // Addressing modes (one decimal digit)
  localparam logic [3:0] MODE_POS = 4'd0;
  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_REL = 4'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [11:0]        word_address;
    logic signed [63:0] data_word;
  } ism_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               out_valid;
    logic signed [63:0] out_value;
    logic [11:0]        program_counter_now;
  } ism_out_t;

  // Memory read address select
  typedef enum logic [1:0] {
    RD_PC  = 2'd0,
    RD_POS = 2'd1,
    RD_EA  = 2'd2,
    RD_EB  = 2'd3
  } ism_rdsel_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch_item;
    logic       clear_all;
    logic       clr_step;
    logic       load_wr;
    logic       q_push;
    logic       mem_rd;
    ism_rdsel_t rd_sel;
    logic       word_ld;
    logic       dec_step;
    logic       k_first;
    logic       k_next;
    logic       ea_ld;
    logic       va_ld;
    logic       vb_ld;
    logic       mul_start;
    logic       mul_step;
    logic       commit;
    logic       set_fault;
    logic       set_halt;
    logic       resp_ld;
    logic [2:0] resp_status;
  } ism_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       halted;
    logic       fault;
    logic       pc_oob;
    logic       q_full;
    logic       q_empty;
    logic       w_neg;
    logic       dec_last;
    logic       op_valid;
    logic       op_halt;
    logic       op_in;
    logic       op_mul;
    logic [1:0] nsrc;
    logic       k_last;
    logic [3:0] mode;
    logic       dest;
    logic       pos_oob;
    logic       addr_oob;
    logic       mul_last;
    logic       jmp_fault;
    logic       clr_last;
  } ism_stat_t;

  // Shift one binary bit into a five digit BCD accumulator (mod 100000)
  function automatic logic [19:0] bcd_dbl(input logic [19:0] d, input logic b);
    logic [19:0] r;
    logic [3:0]  di;
    logic [4:0]  t;
    logic        c;
    c = b;
    r = '0;
    for (int i = 0; i < 5; i++) begin
      di = d[4*i +: 4];
      t  = {di, c};
      if (di >= 4'd5) begin
        t = t - 5'd10;
      end
      r[4*i +: 4] = t[3:0];
      c = (di >= 4'd5);
    end
    return r;
  endfunction

  // Queue pointer helpers, pointers count modulo 2*INQ_DEPTH
  function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
    return (p == QP_W'(2 * INQ_DEPTH - 1)) ? '0 : p + QP_W'(1);
  endfunction

  function automatic logic [QI_W-1:0] ptr_idx(input logic [QP_W-1:0] p);
    logic [QP_W-1:0] t;
    t = (p >= QP_W'(INQ_DEPTH)) ? p - QP_W'(INQ_DEPTH) : p;
    return t[QI_W-1:0];
  endfunction

  function automatic logic q_is_full(input logic [QP_W-1:0] wp, input logic [QP_W-1:0] rp);
    logic [QP_W:0] t;
    t = {1'b0, wp} + (QP_W+1)'(2 * INQ_DEPTH) - {1'b0, rp};
    if (t >= (QP_W+1)'(2 * INQ_DEPTH)) begin
      t = t - (QP_W+1)'(2 * INQ_DEPTH);
    end
    return (t >= (QP_W+1)'(INQ_DEPTH));
  endfunction

  // Program counter as shown on the result: low 12 bits
  function automatic logic [11:0] pc_out(input logic [PC_W-1:0] p);
    logic [PC_W+11:0] t;
    t = {12'd0, p};
    return t[11:0];
  endfunction

endpackage

/* rtl/core/intcode_step_machine.sv */
// Intcode step machine top level: one command word in, one result word out.
// Step: one fetch, a decimal split at 3 bits per cycle, operand and value
// reads on the single memory read port, and partial products for a multiply;
// a step on a halted or faulted machine answers without a fetch.
// Load and push answer without a fetch; one command word in flight at a time.
// rst_n and the reset command sweep all 4096 memory words to zero, one a cycle.
module intcode_step_machine import ism_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ism_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ism_out_t out_data
);

  ism_cmd_t  cmd;
  ism_stat_t stat;

  // Sequencer
  ism_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  ism_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* rtl/core/ism_ctrl.sv */
// Sequencing state machine of the Intcode step machine.
module ism_ctrl import ism_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ism_stat_t stat,
  output ism_cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DISP  = 16'h0002,
    S_CLEAR = 16'h0004,
    S_FDATA = 16'h0008,
    S_DEC   = 16'h0010,
    S_OPDEC = 16'h0020,
    S_OPND  = 16'h0040,
    S_OPWT  = 16'h0080,
    S_VA    = 16'h0100,
    S_VAW   = 16'h0200,
    S_VB    = 16'h0400,
    S_VBW   = 16'h0800,
    S_MUL   = 16'h1000,
    S_EXEC  = 16'h2000,
    S_RESP  = 16'h4000,
    S_SPARE = 16'h8000
  } ism_state_t;

  ism_state_t state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       clr_resp_r, clr_resp_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    st_nxt       = st_r;
    clr_resp_nxt = clr_resp_r;
    cmd          = '0;
    cmd.rd_sel   = RD_PC;
    cmd.resp_status = st_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd)
          CMD_RESET: begin
            cmd.clear_all = 1'b1;
            clr_resp_nxt  = 1'b1;
            st_nxt        = ST_DONE;
            state_nxt     = S_CLEAR;
          end
          CMD_LOAD: begin
            cmd.load_wr = 1'b1;
            st_nxt      = ST_DONE;
            state_nxt   = S_RESP;
          end
          CMD_PUSH: begin
            if (stat.q_full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.q_push = 1'b1;
              st_nxt     = ST_DONE;
            end
            state_nxt = S_RESP;
          end
          default: begin
            if (stat.halted) begin
              st_nxt    = ST_HALT;
              state_nxt = S_RESP;
            end else if (stat.fault) begin
              st_nxt    = ST_FAULT;
              state_nxt = S_RESP;
            end else if (stat.pc_oob) begin
              cmd.set_fault = 1'b1;
              st_nxt        = ST_FAULT;
              state_nxt     = S_RESP;
            end else begin
              cmd.mem_rd = 1'b1;
              cmd.rd_sel = RD_PC;
              state_nxt  = S_FDATA;
            end
          end
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_FDATA: begin
        cmd.word_ld = 1'b1;
        if (stat.w_neg) begin
          cmd.set_fault = 1'b1;
          st_nxt        = ST_FAULT;
          state_nxt     = S_RESP;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec_step = 1'b1;
        if (stat.dec_last) begin
          state_nxt = S_OPDEC;
        end
      end
      S_OPDEC: begin
        if (!stat.op_valid) begin
          cmd.set_fault = 1'b1;
          st_nxt        = ST_FAULT;
          state_nxt     = S_RESP;
        end else if (stat.op_halt) begin
          cmd.set_halt = 1'b1;
          st_nxt       = ST_HALT;
          state_nxt    = S_RESP;
        end else if (stat.op_in && stat.q_empty) begin
          st_nxt    = ST_WAIT;
          state_nxt = S_RESP;
        end else begin
          cmd.k_first = 1'b1;
          state_nxt   = S_OPND;
        end
      end
      S_OPND: begin
        if (stat.pos_oob) begin
          cmd.set_fault = 1'b1;
          st_nxt        = ST_FAULT;
          state_nxt     = S_RESP;
        end else if (stat.mode == MODE_POS || stat.mode == MODE_REL) begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_POS;
          state_nxt  = S_OPWT;
        end else if (stat.mode == MODE_IMM && !stat.dest) begin
          cmd.ea_ld = 1'b1;
          if (stat.k_last) begin
            state_nxt = (stat.nsrc == 2'd0) ? S_EXEC : S_VA;
          end else begin
            cmd.k_next = 1'b1;
          end
        end else begin
          cmd.set_fault = 1'b1;
          st_nxt        = ST_FAULT;
          state_nxt     = S_RESP;
        end
      end
      S_OPWT: begin
        if (stat.addr_oob) begin
          cmd.set_fault = 1'b1;
          st_nxt        = ST_FAULT;
          state_nxt     = S_RESP;
        end else begin
          cmd.ea_ld = 1'b1;
          if (stat.k_last) begin
            state_nxt = (stat.nsrc == 2'd0) ? S_EXEC : S_VA;
          end else begin
            cmd.k_next = 1'b1;
            state_nxt  = S_OPND;
          end
        end
      end
      S_VA: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_EA;
        state_nxt  = S_VAW;
      end
      S_VAW: begin
        cmd.va_ld = 1'b1;
        state_nxt = (stat.nsrc == 2'd2) ? S_VB : S_EXEC;
      end
      S_VB: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_EB;
        state_nxt  = S_VBW;
      end
      S_VBW: begin
        cmd.vb_ld     = 1'b1;
        cmd.mul_start = 1'b1;
        state_nxt     = stat.op_mul ? S_MUL : S_EXEC;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.jmp_fault) begin
          cmd.set_fault = 1'b1;
          st_nxt        = ST_FAULT;
        end else begin
          cmd.commit = 1'b1;
          st_nxt     = ST_DONE;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // result register frees up when the previous word drains
        if (!out_valid_r || out_ready) begin
          cmd.resp_ld   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers; reset starts the memory clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      st_r        <= ST_DONE;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      clr_resp_r  <= (state_r == S_CLEAR && stat.clr_last) ? 1'b0 : clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/ism_dpath.sv */
// Datapath of the Intcode step machine: memories, registers and arithmetic.
module ism_dpath import ism_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ism_in_t   in_data,
  input  ism_cmd_t  cmd,
  output ism_stat_t stat,
  output ism_out_t  out_data
);

  // Storage
  logic [63:0] mem [MEM_WORDS];
  logic [63:0] queue_mem [INQ_DEPTH];

  ism_in_t         item_r;
  logic [PC_W-1:0] pc_r;
  logic [63:0]     base_r;
  logic [QP_W-1:0] rdp_r, wrp_r;
  logic            halted_r, fault_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [63:0]     rd_data_r;
  logic [63:0]     q_rd_r;
  logic [62:0]     w_r;
  logic [19:0]     dig_r, dig_nxt;
  logic [DC_W-1:0] dcnt_r;
  logic [1:0]      k_r;
  logic [AW-1:0]   ea1_r, ea2_r, ea3_r;
  logic [63:0]     va_r, vb_r;
  logic [1:0]      mph_r;
  logic [63:0]     prod_r, acc_r;
  logic            emit_r;
  logic [63:0]     emit_val_r;
  ism_out_t        out_r;

  // Decoded instruction
  logic [6:0]  op;
  logic [3:0]  ma, mb, mc, mode;
  logic        op_valid, op_arith, op_jump;
  logic [1:0]  nres, nsrc;
  logic [PC_W-1:0] pos;
  logic [63:0] a_calc;
  logic        taken;
  logic [AW+11:0] la;
  logic        la_ok;

  // Memory port
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0]   mem_wd;
  logic [63:0]   res;
  logic [31:0]   mul_a, mul_b;

  assign op = 7'({dig_r[7:4], 3'b000}) + 7'({dig_r[7:4], 1'b0}) + 7'(dig_r[3:0]);
  assign ma = dig_r[11:8];
  assign mb = dig_r[15:12];
  assign mc = dig_r[19:16];

  // Instruction class
  always_comb begin
    op_valid = 1'b1;
    op_arith = 1'b0;
    op_jump  = 1'b0;
    nres     = 2'd1;
    nsrc     = 2'd1;
    case (op)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
        op_arith = 1'b1;
        nres     = 2'd3;
        nsrc     = 2'd2;
      end
      OP_IN: begin
        nsrc = 2'd0;
      end
      OP_OUT, OP_ARB: begin
        nsrc = 2'd1;
      end
      OP_JT, OP_JF: begin
        op_jump = 1'b1;
        nres    = 2'd2;
        nsrc    = 2'd2;
      end
      OP_HALT: begin
        nsrc = 2'd0;
      end
      default: begin
        op_valid = 1'b0;
      end
    endcase
  end

  // Operand addressing
  always_comb begin
    case (k_r)
      2'd1:    mode = ma;
      2'd2:    mode = mb;
      default: mode = mc;
    endcase
  end

  assign pos = pc_r + PC_W'(k_r);

  always_comb begin
    if (mode == MODE_REL) begin
      a_calc = base_r + rd_data_r;
    end else if (mode == MODE_IMM) begin
      a_calc = 64'(pos);
    end else begin
      a_calc = rd_data_r;
    end
  end

  assign taken = ((op == OP_JT) == (va_r != 64'd0));
  assign la    = {{AW{1'b0}}, item_r.word_address};
  assign la_ok = (la < (AW+12)'(MEM_WORDS));

  // Status toward the controller
  always_comb begin
    stat.cmd       = item_r.cmd;
    stat.halted    = halted_r;
    stat.fault     = fault_r;
    stat.pc_oob    = (pc_r >= PC_W'(MEM_WORDS));
    stat.q_full    = q_is_full(wrp_r, rdp_r);
    stat.q_empty   = (wrp_r == rdp_r);
    stat.w_neg     = rd_data_r[63];
    stat.dec_last  = (dcnt_r == DC_W'(DEC_STEPS - 1));
    stat.op_valid  = op_valid;
    stat.op_halt   = (op == OP_HALT);
    stat.op_in     = (op == OP_IN);
    stat.op_mul    = (op == OP_MUL);
    stat.nsrc      = nsrc;
    stat.k_last    = (k_r == nres);
    stat.mode      = mode;
    stat.dest      = (op_arith && k_r == 2'd3) || (op == OP_IN && k_r == 2'd1);
    stat.pos_oob   = (pos >= PC_W'(MEM_WORDS));
    stat.addr_oob  = (a_calc >= 64'(MEM_WORDS));
    stat.mul_last  = (mph_r == 2'd3);
    stat.jmp_fault = op_jump && taken && (vb_r >= 64'(MEM_WORDS));
    stat.clr_last  = (clr_cnt_r == AW'(MEM_WORDS - 1));
  end

  // Arithmetic result of a three-operand instruction
  always_comb begin
    case (op)
      OP_ADD:  res = va_r + vb_r;
      OP_MUL:  res = acc_r;
      OP_LT:   res = ($signed(va_r) < $signed(vb_r)) ? 64'd1 : 64'd0;
      default: res = (va_r == vb_r) ? 64'd1 : 64'd0;
    endcase
  end

  // Memory write and read port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ea3_r;
    mem_wd = res;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (cmd.load_wr) begin
      mem_we = la_ok;
      mem_wa = la[AW-1:0];
      mem_wd = item_r.data_word;
    end else if (cmd.commit) begin
      mem_we = op_arith || (op == OP_IN);
      mem_wa = (op == OP_IN) ? ea1_r : ea3_r;
      mem_wd = (op == OP_IN) ? q_rd_r : res;
    end
    case (cmd.rd_sel)
      RD_PC:   mem_ra = pc_r[AW-1:0];
      RD_POS:  mem_ra = pos[AW-1:0];
      RD_EA:   mem_ra = ea1_r;
      default: mem_ra = ea2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Input queue storage
  always_ff @(posedge clk) begin
    if (cmd.q_push) begin
      queue_mem[ptr_idx(wrp_r)] <= item_r.data_word;
    end
    q_rd_r <= queue_mem[ptr_idx(rdp_r)];
  end

  // Decimal split: three instruction bits per cycle into BCD digits
  always_comb begin
    dig_nxt = dig_r;
    for (int j = 0; j < DEC_BITS; j++) begin
      dig_nxt = bcd_dbl(dig_nxt, w_r[62 - j]);
    end
  end

  // Multiplier operands: one 32x32 product per cycle
  always_comb begin
    case (mph_r)
      2'd0:    begin mul_a = va_r[31:0];  mul_b = vb_r[31:0];  end
      2'd1:    begin mul_a = va_r[31:0];  mul_b = vb_r[63:32]; end
      default: begin mul_a = va_r[63:32]; mul_b = vb_r[31:0];  end
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_r <= in_data;
      emit_r <= 1'b0;
    end
    if (cmd.word_ld) begin
      w_r    <= rd_data_r[62:0];
      dig_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.dec_step) begin
      w_r    <= {w_r[62-DEC_BITS:0], {DEC_BITS{1'b0}}};
      dig_r  <= dig_nxt;
      dcnt_r <= dcnt_r + DC_W'(1);
    end
    if (cmd.k_first) begin
      k_r <= 2'd1;
    end else if (cmd.k_next) begin
      k_r <= k_r + 2'd1;
    end
    if (cmd.ea_ld) begin
      case (k_r)
        2'd1:    ea1_r <= a_calc[AW-1:0];
        2'd2:    ea2_r <= a_calc[AW-1:0];
        default: ea3_r <= a_calc[AW-1:0];
      endcase
    end
    if (cmd.va_ld) begin
      va_r <= rd_data_r;
    end
    if (cmd.vb_ld) begin
      vb_r <= rd_data_r;
    end
    // low 64 bits of the product from three partial products
    if (cmd.mul_start) begin
      mph_r <= 2'd0;
    end else if (cmd.mul_step) begin
      mph_r  <= mph_r + 2'd1;
      prod_r <= mul_a * mul_b;
      case (mph_r)
        2'd0:    acc_r <= acc_r;
        2'd1:    acc_r <= prod_r;
        default: acc_r <= acc_r + {prod_r[31:0], 32'd0};
      endcase
    end
    if (cmd.commit && op == OP_OUT) begin
      emit_r     <= 1'b1;
      emit_val_r <= va_r;
    end
    if (cmd.resp_ld) begin
      out_r.status              <= cmd.resp_status;
      out_r.out_valid           <= emit_r;
      out_r.out_value           <= emit_r ? emit_val_r : 64'd0;
      out_r.program_counter_now <= pc_out(pc_r);
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      pc_r      <= '0;
      base_r    <= '0;
      rdp_r     <= '0;
      wrp_r     <= '0;
      halted_r  <= 1'b0;
      fault_r   <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      if (cmd.q_push) begin
        wrp_r <= ptr_inc(wrp_r);
      end
      if (cmd.set_fault) begin
        fault_r <= 1'b1;
      end
      if (cmd.set_halt) begin
        halted_r <= 1'b1;
      end
      if (cmd.commit) begin
        if (op_arith) begin
          pc_r <= pc_r + PC_W'(4);
        end else if (op_jump) begin
          pc_r <= taken ? vb_r[PC_W-1:0] : pc_r + PC_W'(3);
        end else begin
          pc_r <= pc_r + PC_W'(2);
        end
        if (op == OP_IN) begin
          rdp_r <= ptr_inc(rdp_r);
        end
        if (op == OP_ARB) begin
          base_r <= base_r + va_r;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/core/intcode_step_machine_chk.sv */
// Port-level checker for the Intcode step machine, bound to the top level.
`include "intcode_step_machine_assert.svh"

module intcode_step_machine_chk import ism_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input ism_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input ism_out_t out_data
);

  // one command word at a time
  `ISM_ASSERT_NEXT(a_in_single, in_valid && in_ready, !in_ready)
  // stalled result holds
  `ISM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // status codes stay in range
  `ISM_ASSERT_NOW(a_status_range, out_valid, out_data.status <= ST_FULL)
  // an emitted value only comes with a completed step
  `ISM_ASSERT_NOW(a_emit_done, out_valid && out_data.out_valid, out_data.status == ST_DONE)
  // without an emitted value the value field reads as zero
  `ISM_ASSERT_NOW(a_value_zero, out_valid && !out_data.out_valid, out_data.out_value == 64'sd0)

endmodule

bind intcode_step_machine intcode_step_machine_chk u_chk (.*);

/* test/tb.sv */
// Testbench for the Intcode step machine: predicted results checked word by word.
module tb;
  import ism_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ism_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ism_out_t out_data;

  intcode_step_machine dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [63:0] mem_img [MEM_WORDS];
  logic [63:0] inq_img [INQ_DEPTH];
  int unsigned pc_img;
  logic [63:0] base_img;
  int unsigned rd_img, wr_img;
  bit          halt_img, fault_img;

  ism_in_t  pending_words [$];
  ism_out_t expected_words [$];
  int       errors = 0;
  int       n_out = 0, n_steps = 0, n_faults = 0, n_halts = 0;
  bit       stim_done = 1'b0;
  bit       hold_start = 1'b0;
  bit       hold_rx = 1'b0;
  bit       hold_done = 1'b0;

  task automatic clear_image();
    for (int i = 0; i < MEM_WORDS; i++) mem_img[i] = '0;
    for (int i = 0; i < INQ_DEPTH; i++) inq_img[i] = '0;
    pc_img = 0; base_img = '0; rd_img = 0; wr_img = 0;
    halt_img = 1'b0; fault_img = 1'b0;
  endtask

  function automatic int unsigned inq_count();
    return (wr_img + 2 * INQ_DEPTH - rd_img) % (2 * INQ_DEPTH);
  endfunction

  // Operand k -> address; returns 0 on fault
  function automatic bit operand_addr(int unsigned k, int unsigned mode, bit dest,
                                      output logic [63:0] addr);
    int unsigned pos;
    logic [63:0] a;
    pos = pc_img + k;
    addr = '0;
    if (pos >= MEM_WORDS) return 1'b0;
    if (mode == MODE_POS) a = mem_img[pos];
    else if (mode == MODE_IMM) begin
      if (dest) return 1'b0;
      a = 64'(pos);
    end else if (mode == MODE_REL) a = base_img + mem_img[pos];
    else return 1'b0;
    if (a >= 64'(MEM_WORDS)) return 1'b0;
    addr = a;
    return 1'b1;
  endfunction

  // Execute one instruction in the image
  task automatic exec_instr(output logic [2:0] st, output logic ov, output logic [63:0] val);
    logic [63:0] w, q, ea, eb, ec, va, vb;
    int unsigned op, ma, mb, mc;
    bit ok;
    ov = 1'b0; val = '0; st = ST_DONE;
    if (halt_img) begin st = ST_HALT; return; end
    if (fault_img) begin st = ST_FAULT; return; end
    if (pc_img >= MEM_WORDS) begin fault_img = 1'b1; st = ST_FAULT; return; end
    w = mem_img[pc_img];
    if (w[63]) begin fault_img = 1'b1; st = ST_FAULT; return; end
    op = w % 100; q = w / 100;
    ma = q % 10; q = q / 10;
    mb = q % 10; q = q / 10;
    mc = q % 10;
    ok = 1'b0;
    case (op)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
        ok = operand_addr(1, ma, 0, ea) && operand_addr(2, mb, 0, eb) &&
             operand_addr(3, mc, 1, ec);
        if (ok) begin
          va = mem_img[ea]; vb = mem_img[eb];
          if (op == OP_ADD) mem_img[ec] = va + vb;
          else if (op == OP_MUL) mem_img[ec] = va * vb;
          else if (op == OP_LT) mem_img[ec] = ($signed(va) < $signed(vb)) ? 64'd1 : 64'd0;
          else mem_img[ec] = (va == vb) ? 64'd1 : 64'd0;
          pc_img += 4;
          return;
        end
      end
      OP_IN: begin
        if (inq_count() == 0) begin st = ST_WAIT; return; end
        ok = operand_addr(1, ma, 1, ea);
        if (ok) begin
          mem_img[ea] = inq_img[rd_img % INQ_DEPTH];
          rd_img = (rd_img + 1) % (2 * INQ_DEPTH);
          pc_img += 2;
          return;
        end
      end
      OP_OUT: begin
        ok = operand_addr(1, ma, 0, ea);
        if (ok) begin
          ov = 1'b1; val = mem_img[ea]; pc_img += 2;
          return;
        end
      end
      OP_JT, OP_JF: begin
        ok = operand_addr(1, ma, 0, ea) && operand_addr(2, mb, 0, eb);
        if (ok) begin
          va = mem_img[ea]; vb = mem_img[eb];
          if ((op == OP_JT) == (va != 0)) begin
            if (vb >= 64'(MEM_WORDS)) ok = 1'b0;
            else pc_img = int'(vb);
          end else pc_img += 3;
          if (ok) return;
        end
      end
      OP_ARB: begin
        ok = operand_addr(1, ma, 0, ea);
        if (ok) begin
          base_img += mem_img[ea]; pc_img += 2;
          return;
        end
      end
      OP_HALT: begin halt_img = 1'b1; st = ST_HALT; return; end
      default: ;
    endcase
    fault_img = 1'b1;
    st = ST_FAULT;
  endtask

  // Predict the result word of one accepted command word
  task automatic predict_word(input ism_in_t w);
    ism_out_t r;
    logic [2:0] st;
    logic ov;
    logic [63:0] val;
    st = ST_DONE; ov = 1'b0; val = '0;
    case (w.cmd)
      CMD_RESET: clear_image();
      CMD_LOAD: if (w.word_address < MEM_WORDS) mem_img[w.word_address] = w.data_word;
      CMD_PUSH: begin
        if (inq_count() >= INQ_DEPTH) st = ST_FULL;
        else begin
          inq_img[wr_img % INQ_DEPTH] = w.data_word;
          wr_img = (wr_img + 1) % (2 * INQ_DEPTH);
        end
      end
      default: begin
        exec_instr(st, ov, val);
        n_steps++;
        if (ov) n_out++;
        if (st == ST_FAULT) n_faults++;
        if (st == ST_HALT) n_halts++;
      end
    endcase
    r.status = st; r.out_valid = ov; r.out_value = val;
    r.program_counter_now = pc_img[11:0];
    expected_words.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Driver: offer the next pending word after a random gap, none during a burst
  int tx_gap = 0;
  bit burst = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_word(in_data);
      if (!in_valid || in_ready) begin
        if (tx_gap > 0 && !burst) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          tx_gap <= gap_len();
        end else in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here once started
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      if (hold_cnt >= 400) begin
        hold_rx   <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_rx  <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // Monitor: check results and stall at random
  int rx_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_data.status), 0);
        end else begin
          ism_out_t e;
          e = expected_words.pop_front();
          if (out_data.status !== e.status)
            report_mismatch("status", 64'(out_data.status), 64'(e.status));
          if (out_data.out_valid !== e.out_valid)
            report_mismatch("out_valid", 64'(out_data.out_valid), 64'(e.out_valid));
          if (out_data.out_value !== e.out_value)
            report_mismatch("out_value", out_data.out_value, e.out_value);
          if (out_data.program_counter_now !== e.program_counter_now)
            report_mismatch("pc", 64'(out_data.program_counter_now),
                            64'(e.program_counter_now));
        end
      end
      if (hold_rx) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0 && !burst) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
      end
    end
  end

  // Watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 30000) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic ism_in_t mk(input logic [1:0] c, input logic [11:0] a,
                                 input logic [63:0] d);
    ism_in_t w;
    w.cmd = c; w.word_address = a; w.data_word = d;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random instruction word: mostly valid opcodes and modes
  function automatic logic [63:0] rand_instr();
    int unsigned ops [10] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 99};
    int unsigned op, m;
    if ($urandom_range(0, 19) == 0) return rand64();
    op = ops[$urandom_range(0, 9)];
    if ($urandom_range(0, 24) == 0) op = $urandom_range(0, 98);
    m = $urandom_range(0, 2) + 10 * $urandom_range(0, 2) + 100 * $urandom_range(0, 2);
    if ($urandom_range(0, 24) == 0) m = $urandom_range(0, 999);
    if ((op == 3 || op == 1 || op == 2 || op == 7 || op == 8) && $urandom_range(0, 4) != 0)
      m = m % 100;
    if ($urandom_range(0, 9) == 0) m = m + 1000 * $urandom_range(1, 9);
    return 64'(op + 100 * m);
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return 64'($urandom_range(0, 4095));
      2: return -64'($urandom_range(0, 3));
      default: return 64'($urandom_range(0, 31));
    endcase
  endfunction

  // Random program near address 0, then a run of steps with pushes mixed in
  task automatic queue_program();
    int unsigned len;
    len = $urandom_range(8, 24);
    for (int i = 0; i < len; i++)
      pending_words.push_back(mk(CMD_LOAD, 12'(i), (i % 4 == 0) ? rand_instr() : rand_operand()));
    for (int i = 0; i < 4; i++)
      pending_words.push_back(mk(CMD_LOAD, 12'($urandom_range(0, 31)), rand64()));
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 4) == 0) pending_words.push_back(mk(CMD_PUSH, 12'($urandom()), rand64()));
      else pending_words.push_back(mk(CMD_STEP, 12'($urandom()), rand64()));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    clear_image();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: load extremes, add wrap, in/out, jumps, halt
    pending_words.push_back(mk(CMD_LOAD, 12'd4095, 64'h7fff_ffff_ffff_ffff));
    pending_words.push_back(mk(CMD_LOAD, 12'd100, 64'h8000_0000_0000_0000));
    pending_words.push_back(mk(CMD_LOAD, 12'd0, 64'd1101));   // add imm,imm -> [9]
    pending_words.push_back(mk(CMD_LOAD, 12'd1, 64'hffff_ffff_ffff_ffff));
    pending_words.push_back(mk(CMD_LOAD, 12'd2, 64'd5));
    pending_words.push_back(mk(CMD_LOAD, 12'd3, 64'd9));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));
    pending_words.push_back(mk(CMD_LOAD, 12'd4, 64'd3));      // input, empty queue
    pending_words.push_back(mk(CMD_LOAD, 12'd5, 64'd20));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));
    pending_words.push_back(mk(CMD_PUSH, 12'd0, 64'h8000_0000_0000_0001));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));
    pending_words.push_back(mk(CMD_LOAD, 12'd6, 64'd4));      // output [20]
    pending_words.push_back(mk(CMD_LOAD, 12'd7, 64'd20));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));
    pending_words.push_back(mk(CMD_LOAD, 12'd8, 64'd1105));   // jump taken to 30
    pending_words.push_back(mk(CMD_LOAD, 12'd9, 64'd1));
    pending_words.push_back(mk(CMD_LOAD, 12'd10, 64'd30));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));
    pending_words.push_back(mk(CMD_LOAD, 12'd30, 64'd99));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));     // step after halt
    pending_words.push_back(mk(CMD_RESET, 12'hfff, '1));
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));     // opcode 0 faults
    pending_words.push_back(mk(CMD_STEP, 12'd0, 64'd0));
    wait_drained();

    // Fill the queue past full while the receiver holds off
    pending_words.push_back(mk(CMD_RESET, 12'd0, 64'd0));
    wait_drained();
    hold_start = 1'b1;
    for (int i = 0; i < 36; i++) pending_words.push_back(mk(CMD_PUSH, 12'($urandom()), rand64()));
    wait_drained();

    // Random programs; reset now and then, bursts without idling
    while (n_steps < 330) begin
      burst = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) pending_words.push_back(mk(CMD_RESET, 12'($urandom()), rand64()));
      else begin
        pending_words.push_back(mk(CMD_LOAD, 12'($urandom()), rand64()));
      end
      queue_program();
      while (pending_words.size() > 0) @(posedge clk);
    end
    burst = 1'b0;
    wait_drained();
    stim_done = 1'b1;

    $display("covered %0d steps: %0d outputs, %0d faults, %0d halts", n_steps, n_out,
             n_faults, n_halts);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ism_pkg.sv
rtl/core/ism_ctrl.sv
rtl/core/ism_dpath.sv
rtl/core/intcode_step_machine.sv
rtl/core/intcode_step_machine_chk.sv
test/tb.sv
